// ----- src/elap_pkg.sv -----
`default_nettype none
package elap_pkg;

	// Sample format is fixed by the Q2.13 input fields
	localparam int SAMPLE_W = 16;
	localparam int WIN_W    = 16;
	localparam int OUT_W    = 36;

	// Slicer error magnitude width: covers |x| plus the largest reference level
	localparam int ERR_W = ((SAMPLE_W > 14) ? SAMPLE_W : 14) + 1;
	localparam int SQ_W  = 2 * ERR_W;

	// Window queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QLVL_W = 3;

	typedef enum logic [1:0] {
		MODE_BPSK  = 2'd0,
		MODE_QPSK  = 2'd1,
		MODE_QAM16 = 2'd2,
		MODE_QAM64 = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_WINDOW = 3'd1,
		REG_WARMUP = 3'd2,
		REG_UPPER  = 3'd3,
		REG_LOWER  = 3'd4
	} reg_idx_t;

	// Decision levels and boundaries, Q2.13
	localparam logic [ERR_W-1:0] D_BPSK    = ERR_W'(8192);
	localparam logic [ERR_W-1:0] D_QPSK    = ERR_W'(5793);
	localparam logic [ERR_W-1:0] D16_1     = ERR_W'(2735);
	localparam logic [ERR_W-1:0] D16_3     = ERR_W'(3 * 2735);
	localparam logic [ERR_W-1:0] B16_1     = ERR_W'(2 * 2735);
	localparam logic [ERR_W-1:0] D64_1     = ERR_W'(1346);
	localparam logic [ERR_W-1:0] D64_3     = ERR_W'(3 * 1346);
	localparam logic [ERR_W-1:0] D64_5     = ERR_W'(5 * 1346);
	localparam logic [ERR_W-1:0] D64_7     = ERR_W'(7 * 1346);
	localparam logic [ERR_W-1:0] B64_1     = ERR_W'(2 * 1346);
	localparam logic [ERR_W-1:0] B64_2     = ERR_W'(4 * 1346);
	localparam logic [ERR_W-1:0] B64_3     = ERR_W'(6 * 1346);

	// Dispersion scale, unsigned Q0.15
	localparam logic [14:0] SCALE_QAM16 = 15'd31035;
	localparam logic [14:0] SCALE_QAM64 = 15'd30779;
	localparam int          SCALE_ROUND = 16384;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] in_i;
		logic signed [SAMPLE_W-1:0] in_q;
	} sample_t;

	typedef struct packed {
		logic [OUT_W-1:0] avg_dispersion;
		logic             change_valid;
		logic [1:0]       new_index;
	} result_t;

	typedef struct packed {
		mode_t            mode;
		logic [WIN_W-1:0] len;
	} win_ctl_t;

endpackage
`default_nettype wire

// ----- src/elap_queue.sv -----
`default_nettype none
module elap_queue
	import elap_pkg::*;
#(
	parameter int WIDTH = 74
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [WIDTH-1:0]  push_data,
	input  wire logic              pop,
	output logic      [WIDTH-1:0]  pop_data,
	output logic      [QLVL_W-1:0] level,
	output logic                   full,
	output logic                   empty
);

	logic [WIDTH-1:0]  mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] level_q;

	assign pop_data = mem_q[rd_ptr_q];
	assign level    = level_q;
	assign full     = (level_q == QLVL_W'(QDEPTH));
	assign empty    = (level_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/elap_front.sv -----
`default_nettype none
module elap_front
	import elap_pkg::*;
#(
	parameter int SUM_WIDTH   = 56,
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire sample_t              in_data,
	input  wire mode_t                mode,
	input  wire logic [WIN_W-1:0]     window_length,
	input  wire logic [WIN_W-1:0]     warmup_length,
	input  wire logic [QLVL_W-1:0]    q_level,
	output logic                      q_push,
	output logic      [SUM_WIDTH-1:0] q_sum,
	output win_ctl_t                  q_ctl
);

	localparam int CMP_W = (COUNT_WIDTH > WIN_W) ? COUNT_WIDTH : WIN_W;
	localparam int ACC_W = ((SUM_WIDTH > SQ_W + 1) ? SUM_WIDTH : SQ_W + 1) + 1;
	localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

	function automatic logic [ERR_W-1:0] slice_err(
		input logic signed [SAMPLE_W-1:0] x,
		input mode_t                      md,
		input logic                       q_axis
	);
		logic signed [ERR_W-1:0] xs;
		logic        [ERR_W-1:0] m;
		logic        [ERR_W-1:0] r;
		xs = {{(ERR_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
		m  = xs[ERR_W-1] ? ERR_W'(-xs) : ERR_W'(xs);
		case (md)
			MODE_BPSK:  r = q_axis ? '0 : D_BPSK;
			MODE_QPSK:  r = D_QPSK;
			MODE_QAM16: r = (m >= B16_1) ? D16_3 : D16_1;
			MODE_QAM64: r = (m >= B64_3) ? D64_7 :
				(m >= B64_2) ? D64_5 : (m >= B64_1) ? D64_3 : D64_1;
			default:    r = D_QPSK;
		endcase
		return (m >= r) ? (m - r) : (r - m);
	endfunction

	logic                   measuring_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [SUM_WIDTH-1:0]   sum_q;

	logic                   valid_s1, close_s1;
	sample_t                smp_s1;
	win_ctl_t               ctl_s1;
	logic                   valid_s2, close_s2;
	logic [ERR_W-1:0]       err_i_s2, err_q_s2;
	win_ctl_t               ctl_s2;
	logic                   valid_s3, close_s3;
	logic [SQ_W-1:0]        sq_i_s3, sq_q_s3;
	win_ctl_t               ctl_s3;

	logic                   accept;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic [CMP_W-1:0]       count_cmp;
	logic [WIN_W-1:0]       win_len;
	logic [QLVL_W:0]        pending;
	logic [ACC_W-1:0]       acc_total;
	logic [SUM_WIDTH-1:0]   sum_next;

	// Reserve a queue slot for every window close still in the pipe
	assign pending  = (QLVL_W + 1)'(valid_s1 & close_s1) + (QLVL_W + 1)'(valid_s2 & close_s2)
		+ (QLVL_W + 1)'(valid_s3 & close_s3);
	assign in_stall = ((QLVL_W + 1)'(q_level) + pending) >= (QLVL_W + 1)'(QDEPTH);
	assign accept   = in_valid && !in_stall;

	assign count_inc = count_q + 1'b1;
	assign count_cmp = CMP_W'(count_inc);
	assign win_len   = (window_length == '0) ? WIN_W'(1) : window_length;

	assign acc_total = ACC_W'(sum_q) + ACC_W'(sq_i_s3) + ACC_W'(sq_q_s3);
	assign sum_next  = (acc_total > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_total[SUM_WIDTH-1:0];

	assign q_push = valid_s3 && close_s3;
	assign q_sum  = sum_next;
	assign q_ctl  = ctl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measuring_q <= 1'b0;
			count_q     <= '0;
			sum_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
		end else begin
			valid_s1 <= accept && measuring_q;
			if (accept) begin
				if (!measuring_q) begin
					// drop warm-up samples, including the one that ends it
					if (count_cmp >= CMP_W'(warmup_length)) begin
						count_q     <= '0;
						measuring_q <= 1'b1;
					end else begin
						count_q <= count_inc;
					end
				end else begin
					if (count_cmp >= CMP_W'(win_len)) begin
						count_q <= '0;
					end else begin
						count_q <= count_inc;
					end
				end
			end
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (valid_s3) begin
				sum_q <= close_s3 ? '0 : sum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		close_s1   <= (count_cmp >= CMP_W'(win_len));
		smp_s1     <= in_data;
		ctl_s1     <= '{mode: mode, len: win_len};
		close_s2   <= close_s1;
		err_i_s2   <= slice_err(smp_s1.in_i, ctl_s1.mode, 1'b0);
		err_q_s2   <= slice_err(smp_s1.in_q, ctl_s1.mode, 1'b1);
		ctl_s2     <= ctl_s1;
		close_s3   <= close_s2;
		sq_i_s3    <= SQ_W'(err_i_s2 * err_i_s2);
		sq_q_s3    <= SQ_W'(err_q_s2 * err_q_s2);
		ctl_s3     <= ctl_s2;
	end

endmodule
`default_nettype wire

// ----- src/elap_back.sv -----
`default_nettype none
module elap_back
	import elap_pkg::*;
#(
	parameter int SUM_WIDTH = 56
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_empty,
	output logic                      q_pop,
	input  wire logic [SUM_WIDTH-1:0] q_sum,
	input  wire win_ctl_t             q_ctl,
	input  wire logic [OUT_W-1:0]     upper_threshold,
	input  wire logic [OUT_W-1:0]     lower_threshold,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output result_t                   out_data
);

	localparam int CNT_W   = $clog2(SUM_WIDTH);
	localparam int MEAN_XW = (SUM_WIDTH > 41) ? SUM_WIDTH : 41;
	localparam int PROD_W  = 57;
	localparam int DISP_W  = PROD_W - 15;
	localparam logic [MEAN_XW-1:0] MEAN_CAP = MEAN_XW'(1) << 40;
	localparam logic [OUT_W-1:0]   OUT_MAX  = {OUT_W{1'b1}};

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t               state_q;
	mode_t                mode_q;
	logic [WIN_W-1:0]     len_q;
	logic [WIN_W-1:0]     rem_q;
	logic [SUM_WIDTH-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [40:0]          mean_q;
	logic [46:0]          prod_lo_q;
	logic [23:0]          prod_hi_q;
	logic [OUT_W-1:0]     disp_q;
	logic [1:0]           down_hits_q;
	logic [1:0]           up_hits_q;
	logic                 out_valid_q;
	result_t              out_q;

	logic [WIN_W:0]       shifted;
	logic                 fits;
	logic [WIN_W:0]       diff;
	logic [MEAN_XW-1:0]   mean_x;
	logic [40:0]          mean_c;
	logic [14:0]          scale;
	logic [PROD_W-1:0]    scaled;
	logic [DISP_W-1:0]    disp_raw;
	logic                 go_down, go_up, clr_down, clr_up, change;
	logic [1:0]           target;
	logic                 out_free;

	// One quotient bit per cycle, restoring
	assign shifted = {rem_q, quo_q[SUM_WIDTH-1]};
	assign fits    = shifted >= {1'b0, len_q};
	assign diff    = shifted - {1'b0, len_q};

	assign mean_x = MEAN_XW'(quo_q);
	assign mean_c = (mean_x > MEAN_CAP) ? 41'(MEAN_CAP) : mean_x[40:0];
	assign scale  = (mode_q == MODE_QAM16) ? SCALE_QAM16 : SCALE_QAM64;

	assign scaled   = PROD_W'({prod_hi_q, 32'b0}) + PROD_W'(prod_lo_q) + PROD_W'(SCALE_ROUND);
	assign disp_raw = ((mode_q == MODE_QAM16) || (mode_q == MODE_QAM64)) ?
		scaled[PROD_W-1:15] : DISP_W'(mean_q);

	always_comb begin
		go_down  = 1'b0;
		go_up    = 1'b0;
		clr_down = 1'b0;
		clr_up   = 1'b0;
		case (mode_q)
			MODE_QPSK, MODE_QAM16: begin
				if (disp_q > upper_threshold) begin
					go_down = 1'b1;
				end else if (disp_q < lower_threshold) begin
					go_up = 1'b1;
				end else begin
					clr_down = 1'b1;
					clr_up   = 1'b1;
				end
			end
			MODE_QAM64: begin
				if (disp_q > upper_threshold) begin
					go_down = 1'b1;
				end else begin
					clr_down = 1'b1;
				end
			end
			MODE_BPSK: begin
				if (disp_q < lower_threshold) begin
					go_up = 1'b1;
				end else begin
					clr_up = 1'b1;
				end
			end
			default: begin
				clr_down = 1'b0;
			end
		endcase
	end

	// Second hit on one side, with no in-range window between, asks for the step
	assign change   = (go_down && (down_hits_q != '0)) || (go_up && (up_hits_q != '0));
	assign target   = go_down ? (mode_q - 2'd1) : (mode_q + 2'd1);
	assign out_free = !out_valid_q || !out_stall;

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			down_hits_q <= '0;
			up_hits_q   <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SUM_WIDTH - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						if (clr_down) begin
							down_hits_q <= '0;
						end else if (go_down) begin
							down_hits_q <= (down_hits_q != '0) ? 2'd0 : 2'd1;
						end
						if (clr_up) begin
							up_hits_q <= '0;
						end else if (go_up) begin
							up_hits_q <= (up_hits_q != '0) ? 2'd0 : 2'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			quo_q  <= q_sum;
			rem_q  <= '0;
			len_q  <= q_ctl.len;
			mode_q <= q_ctl.mode;
		end
		if (state_q == ST_DIV) begin
			rem_q <= fits ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
			quo_q <= {quo_q[SUM_WIDTH-2:0], fits};
		end
		if (state_q == ST_MUL) begin
			mean_q    <= mean_c;
			prod_lo_q <= 47'(mean_c[31:0] * scale);
			prod_hi_q <= 24'(mean_c[40:32] * scale);
		end
		if (state_q == ST_SCALE) begin
			disp_q <= (disp_raw > DISP_W'(OUT_MAX)) ? OUT_MAX : disp_raw[OUT_W-1:0];
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_q.avg_dispersion <= disp_q;
			out_q.change_valid   <= change;
			out_q.new_index      <= change ? target : 2'd0;
		end
	end

endmodule
`default_nettype wire

// ----- src/evm_link_adaptation_probe.sv -----
// Pipeline: a window-closing sample passes front stages s1, s2 and s3 before its sum is
//   pushed into the window queue; the back end then divides, scales and tests it.
// Throughput: one sample per cycle while in_stall is low; the back end takes one window at
//   a time (one quotient bit per cycle), so windows shorter than its time per window fill
//   the 4-entry queue and then hold the input off.
// Reset: arst_n clears warm-up, counters, accumulator, queue and hit counters at once
//   and loads the register reset values; no clearing pass is needed.
`default_nettype none
module evm_link_adaptation_probe
	import elap_pkg::*;
#(
	parameter int SUM_WIDTH   = 56,
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire sample_t     in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output result_t          out_data
);

	localparam int Q_WIDTH = SUM_WIDTH + $bits(win_ctl_t);

	// Configuration registers, one per 8-byte slot
	mode_t            mode_q;
	logic [WIN_W-1:0] window_length_q;
	logic [WIN_W-1:0] warmup_length_q;
	logic [OUT_W-1:0] upper_threshold_q;
	logic [OUT_W-1:0] lower_threshold_q;

	logic             cfg_write;
	reg_idx_t         cfg_idx;

	logic                 q_push, q_pop, q_full, q_empty;
	logic [SUM_WIDTH-1:0] q_push_sum;
	win_ctl_t             q_push_ctl;
	logic [Q_WIDTH-1:0]   q_pop_data;
	logic [QLVL_W-1:0]    q_level;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx   = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q            <= MODE_QPSK;
			window_length_q   <= WIN_W'(1024);
			warmup_length_q   <= WIN_W'(1024);
			upper_threshold_q <= {OUT_W{1'b1}};
			lower_threshold_q <= '0;
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_MODE:   mode_q            <= mode_t'(pwdata[1:0]);
				REG_WINDOW: window_length_q   <= pwdata[WIN_W-1:0];
				REG_WARMUP: warmup_length_q   <= pwdata[WIN_W-1:0];
				REG_UPPER:  upper_threshold_q <= pwdata[OUT_W-1:0];
				REG_LOWER:  lower_threshold_q <= pwdata[OUT_W-1:0];
				default:    mode_q            <= mode_q;
			endcase
		end
	end

	// Read back; slots past the list read as zero
	always_comb begin
		case (cfg_idx)
			REG_MODE:   prdata = 64'(mode_q);
			REG_WINDOW: prdata = 64'(window_length_q);
			REG_WARMUP: prdata = 64'(warmup_length_q);
			REG_UPPER:  prdata = 64'(upper_threshold_q);
			REG_LOWER:  prdata = 64'(lower_threshold_q);
			default:    prdata = '0;
		endcase
	end

	// Front: warm-up, slicing, squared error, accumulation, window close
	elap_front #(
		.SUM_WIDTH  (SUM_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.mode         (mode_q),
		.window_length(window_length_q),
		.warmup_length(warmup_length_q),
		.q_level      (q_level),
		.q_push       (q_push),
		.q_sum        (q_push_sum),
		.q_ctl        (q_push_ctl)
	);

	// Closed windows wait here while the divider is busy
	elap_queue #(
		.WIDTH(Q_WIDTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({q_push_sum, q_push_ctl}),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.level    (q_level),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back: mean by serial division, scaling, thresholds and hit counting
	elap_back #(
		.SUM_WIDTH(SUM_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.q_sum          (q_pop_data[Q_WIDTH-1 -: SUM_WIDTH]),
		.q_ctl          (win_ctl_t'(q_pop_data[$bits(win_ctl_t)-1:0])),
		.upper_threshold(upper_threshold_q),
		.lower_threshold(lower_threshold_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data)
	);

	// A window close must always find room: the front reserves slots ahead
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("window queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("window queue read while empty");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_empty)
		else $error("pushed window lost");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.change_valid) |-> (out_data.new_index == 2'd0))
		else $error("index requested without a change");

endmodule
`default_nettype wire
